// ----- hw/rtl/bcc_pkg.sv -----
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned TickW  = 10;
  localparam int unsigned ClickW = 4;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TickW-1:0]  HoldMax  = '1;
  localparam logic [ClickW-1:0] ClickMax = '1;

  localparam logic [TickW-1:0] LongPressRst = TickW'(300);
  localparam logic [TickW-1:0] ShortMinRst  = TickW'(2);
  localparam logic [TickW-1:0] ShortMaxRst  = TickW'(70);
  localparam logic [TickW-1:0] WindowRst    = TickW'(100);

  typedef enum logic [KindW-1:0] {
    KIND_NONE  = 2'd0,
    KIND_LONG  = 2'd1,
    KIND_GROUP = 2'd2
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_PRESS = 2'd0,
    CFG_SHORT_MIN  = 2'd1,
    CFG_SHORT_MAX  = 2'd2,
    CFG_WINDOW     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [TickW-1:0] long_press_ticks;
    logic [TickW-1:0] short_min_ticks;
    logic [TickW-1:0] short_max_ticks;
    logic [TickW-1:0] multi_click_window;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [ClickW-1:0] count;
  } result_t;

endpackage

// ----- hw/rtl/bcc_cfg.sv -----
// ----------------------------------------------------------------------------
// bcc_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module bcc_cfg
  import bcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TickW-1:0]   cfg_wdata,
  output cfg_t               cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ticks   <= LongPressRst;
      cfg_r.short_min_ticks    <= ShortMinRst;
      cfg_r.short_max_ticks    <= ShortMaxRst;
      cfg_r.multi_click_window <= WindowRst;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LONG_PRESS: cfg_r.long_press_ticks   <= cfg_wdata;
        CFG_SHORT_MIN:  cfg_r.short_min_ticks    <= cfg_wdata;
        CFG_SHORT_MAX:  cfg_r.short_max_ticks    <= cfg_wdata;
        CFG_WINDOW:     cfg_r.multi_click_window <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/bcc_core.sv -----
// ----------------------------------------------------------------------------
// bcc_core
// Input sample register, classifier state and per-sample update logic.
// ----------------------------------------------------------------------------
module bcc_core
  import bcc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    in_valid,
  input  logic    in_pressed,
  output logic    in_stall,
  input  logic    out_free,
  output result_t res
);

  logic              smp_valid_r;
  logic              smp_pressed_r;
  logic              armed_r, armed_nxt;
  logic              rel_seen_r, rel_seen_nxt;
  logic              last_r, last_nxt;
  logic [TickW-1:0]  hold_r, hold_nxt;
  logic [ClickW-1:0] clicks_r, clicks_nxt;
  logic [TickW-1:0]  win_r, win_nxt;
  kind_t             kind;
  logic [ClickW-1:0] count;
  logic              restarted;
  logic              advance;
  logic              p;

  // sample stage moves on whenever the result register can take it
  assign advance  = smp_valid_r && out_free;
  assign in_stall = smp_valid_r && !out_free;
  assign p        = smp_pressed_r;

  always_comb begin
    armed_nxt    = armed_r;
    rel_seen_nxt = rel_seen_r;
    last_nxt     = last_r;
    hold_nxt     = hold_r;
    clicks_nxt   = clicks_r;
    win_nxt      = win_r;
    kind         = KIND_NONE;
    count        = '0;
    restarted    = 1'b0;

    // wait for a released level before arming
    if (!armed_nxt) begin
      if (!p) begin
        rel_seen_nxt = 1'b1;
        hold_nxt     = '0;
        last_nxt     = 1'b0;
      end else if (rel_seen_nxt) begin
        armed_nxt    = 1'b1;
        rel_seen_nxt = 1'b0;
      end
    end

    if (armed_nxt) begin
      if (last_nxt == p) begin
        if (hold_nxt != HoldMax) hold_nxt = hold_nxt + TickW'(1);
        if (hold_nxt >= cfg.long_press_ticks) begin
          kind       = KIND_LONG;
          armed_nxt  = 1'b0;
          clicks_nxt = '0;
          win_nxt    = '0;
        end
      end else if (p) begin
        hold_nxt = '0;
      end else begin
        if (hold_nxt >= cfg.short_min_ticks && hold_nxt < cfg.short_max_ticks) begin
          if (clicks_nxt != ClickMax) clicks_nxt = clicks_nxt + ClickW'(1);
          win_nxt   = (cfg.multi_click_window != '0) ? cfg.multi_click_window
                                                     : TickW'(1);
          restarted = 1'b1;
        end else begin
          hold_nxt = '0;
        end
        armed_nxt = 1'b0;
      end
      last_nxt = p;
    end

    // multi-click window countdown; no tick on the restart itself
    if (kind == KIND_NONE && !restarted && win_nxt != '0) begin
      win_nxt = win_nxt - TickW'(1);
      if (win_nxt == '0) begin
        kind       = KIND_GROUP;
        count      = clicks_nxt;
        clicks_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      armed_r     <= 1'b0;
      rel_seen_r  <= 1'b0;
      last_r      <= 1'b0;
      hold_r      <= '0;
      clicks_r    <= '0;
      win_r       <= '0;
    end else begin
      if (!in_stall) smp_valid_r <= in_valid;
      if (advance) begin
        armed_r    <= armed_nxt;
        rel_seen_r <= rel_seen_nxt;
        last_r     <= last_nxt;
        hold_r     <= hold_nxt;
        clicks_r   <= clicks_nxt;
        win_r      <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) smp_pressed_r <= in_pressed;
  end

  assign res.valid = advance;
  assign res.kind  = kind;
  assign res.count = count;

  // a running window always has at least one click behind it
  a_window_has_clicks: assert property (@(posedge clk) disable iff (!rst_n)
    (win_r != '0) |-> (clicks_r != '0))
    else $error("window running with no pending clicks");

  a_group_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && kind == KIND_GROUP) |-> (count != '0))
    else $error("click group reported with zero clicks");

  a_count_only_group: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && kind != KIND_GROUP) |-> (count == '0))
    else $error("click count set outside a group report");

  a_long_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && kind == KIND_LONG) |=> (!armed_r && win_r == '0 && clicks_r == '0))
    else $error("long press left state behind");

  a_sample_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> (smp_valid_r && $stable(smp_pressed_r)))
    else $error("stalled sample lost");

endmodule

// ----- hw/rtl/bcc_out.sv -----
// ----------------------------------------------------------------------------
// bcc_out
// Result register toward the output channel.
// ----------------------------------------------------------------------------
module bcc_out
  import bcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  result_t           res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KindW-1:0]  out_event_kind,
  output logic [ClickW-1:0] out_click_count
);

  logic              valid_r;
  kind_t             kind_r;
  logic [ClickW-1:0] count_r;

  assign out_free = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      kind_r  <= res.kind;
      count_r <= res.count;
    end
  end

  assign out_valid       = valid_r;
  assign out_event_kind  = kind_r;
  assign out_click_count = count_r;

endmodule

// ----- hw/rtl/button_click_classifier.sv -----
// ----------------------------------------------------------------------------
// button_click_classifier
// Push-button long-press and multi-click classifier, one sample per tick.
// ----------------------------------------------------------------------------
// Each input transaction is one scan-tick sample of the button level; each
// sample yields exactly one output transaction (event kind none, long press,
// or finished click group with its count). A sample passes through the
// input register and then the result register, and a new sample is taken
// every cycle while the output side keeps up. Both stages hold under
// out_stall. Configuration writes take effect on the next cycle and
// belong in idle periods.
module button_click_classifier
  import bcc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TickW-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_pressed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KindW-1:0]   out_event_kind,
  output logic [ClickW-1:0]  out_click_count
);

  cfg_t    cfg;
  result_t res;
  logic    out_free;

  bcc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bcc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_pressed (in_pressed),
    .in_stall   (in_stall),
    .out_free   (out_free),
    .res        (res)
  );

  bcc_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res             (res),
    .out_free        (out_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_click_count (out_click_count)
  );

endmodule

// ----- dv/button_click_classifier_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_click_classifier_tb
// Self-checking bench for the button click classifier. Button samples are
// driven as press/release runs shaped around the programmed thresholds. A
// scoreboard class predicts the event of every accepted sample and checks
// each output transaction in order. Both sides idle at random.
// ----------------------------------------------------------------------------

import bcc_pkg::*;

class click_scoreboard;
  typedef struct packed {
    kind_t             kind;
    logic [ClickW-1:0] count;
  } click_event_t;

  logic [TickW-1:0]  long_ticks, min_ticks, max_ticks, window_len;
  bit                armed, release_seen, last_level;
  logic [TickW-1:0]  hold_cnt, window_cnt;
  logic [ClickW-1:0] clicks;
  click_event_t      expected_q[$];
  int                errors;

  function new();
    long_ticks   = LongPressRst;
    min_ticks    = ShortMinRst;
    max_ticks    = ShortMaxRst;
    window_len   = WindowRst;
    armed        = 1'b0;
    release_seen = 1'b0;
    last_level   = 1'b0;
    hold_cnt     = '0;
    window_cnt   = '0;
    clicks       = '0;
    errors       = 0;
  endfunction

  function void set_reg(cfg_idx_t idx, logic [TickW-1:0] value);
    case (idx)
      CFG_LONG_PRESS: long_ticks = value;
      CFG_SHORT_MIN:  min_ticks  = value;
      CFG_SHORT_MAX:  max_ticks  = value;
      CFG_WINDOW:     window_len = value;
      default: ;
    endcase
  endfunction

  // Advance the predicted button state by one accepted sample.
  function void note_sample(bit pressed);
    click_event_t ev;
    bit           restarted;
    ev.kind   = KIND_NONE;
    ev.count  = '0;
    restarted = 1'b0;
    if (!armed) begin
      if (!pressed) begin
        release_seen = 1'b1;
        hold_cnt     = '0;
        last_level   = 1'b0;
      end else if (release_seen) begin
        armed        = 1'b1;
        release_seen = 1'b0;
      end
    end
    if (armed) begin
      if (last_level == pressed) begin
        if (hold_cnt != HoldMax) hold_cnt++;
        if (hold_cnt >= long_ticks) begin
          ev.kind    = KIND_LONG;
          armed      = 1'b0;
          clicks     = '0;
          window_cnt = '0;
        end
      end else if (pressed) begin
        hold_cnt = '0;
      end else begin
        if (hold_cnt >= min_ticks && hold_cnt < max_ticks) begin
          if (clicks != ClickMax) clicks++;
          window_cnt = (window_len != '0) ? window_len : TickW'(1);
          restarted  = 1'b1;
        end else begin
          hold_cnt = '0;
        end
        armed = 1'b0;
      end
      last_level = pressed;
    end
    // a click that just restarted the window skips this tick's countdown
    if (ev.kind == KIND_NONE && !restarted && window_cnt != '0) begin
      window_cnt--;
      if (window_cnt == '0) begin
        ev.kind  = KIND_GROUP;
        ev.count = clicks;
        clicks   = '0;
      end
    end
    expected_q.push_back(ev);
  endfunction

  function void check_result(logic [KindW-1:0] kind, logic [ClickW-1:0] count);
    click_event_t ev;
    if (expected_q.size() == 0) begin
      $display("%0t: result transaction with nothing pending, kind %0d count %0d",
               $time, kind, count);
      errors++;
      return;
    end
    ev = expected_q.pop_front();
    if (kind !== ev.kind) begin
      $display("%0t: event_kind mismatch, expected %0d actual %0d",
               $time, ev.kind, kind);
      errors++;
    end
    if (count !== ev.count) begin
      $display("%0t: click_count mismatch, expected %0d actual %0d",
               $time, ev.count, count);
      errors++;
    end
  endfunction
endclass

module button_click_classifier_tb;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_wr_en  = 1'b0;
  logic [CfgIdxW-1:0] cfg_index  = '0;
  logic [TickW-1:0]   cfg_wdata  = '0;
  logic               in_valid   = 1'b0;
  logic               in_pressed = 1'b0;
  logic               out_stall  = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [KindW-1:0]   out_event_kind;
  logic [ClickW-1:0]  out_click_count;

  click_scoreboard click_sb;
  int              n_sent        = 0;
  bit              hold_off_done = 1'b0;
  bit              burst         = 1'b0;

  button_click_classifier DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pressed      (in_pressed),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_kind  (out_event_kind),
    .out_click_count (out_click_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      click_sb.check_result(out_event_kind, out_click_count);
  end

  // receiver: random stall pattern, plus one long hold-off once traffic runs
  initial begin
    int r, n;
    forever begin
      if (!hold_off_done && n_sent >= 60) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_off_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 10);
        end else if (r < 60) begin
          out_stall <= 1'b0;
          n = $urandom_range(50, 150);
        end else if (r < 95) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          n = $urandom_range(10, 40);
        end
        repeat (n) @(negedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 2);
    if (r < 98) return $urandom_range(3, 8);
    return $urandom_range(15, 50);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back samples need no extra assignment.
  task automatic send_sample(bit pressed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid   <= 1'b0;
      in_pressed <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_pressed <= pressed;
    do @(posedge clk); while (in_stall);
    click_sb.note_sample(pressed);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_run(bit pressed, int n);
    repeat (n) send_sample(pressed);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (click_sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= TickW'(value);
    click_sb.set_reg(idx, TickW'(value));
    @(negedge clk);
  endtask

  task automatic write_regs(int long_v, int min_v, int max_v, int win_v);
    drain();
    write_reg(CFG_LONG_PRESS, long_v);
    write_reg(CFG_SHORT_MIN, min_v);
    write_reg(CFG_SHORT_MAX, max_v);
    write_reg(CFG_WINDOW, win_v);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // One press run then one release run, or random samples if not gentle.
  // Hold count at release is press length minus one. Gentle mode keeps to chained clicks only.
  task automatic run_episode(bit gentle);
    int lp, mn, mx, w, r, h, k, hi;
    lp = click_sb.long_ticks;
    mn = click_sb.min_ticks;
    mx = click_sb.max_ticks;
    w  = click_sb.window_len;
    if (!gentle && $urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 10)) send_sample(1'($urandom));
      return;
    end
    burst = ($urandom_range(0, 9) == 0);
    r = gentle ? 0 : $urandom_range(0, 99);
    if (r < 40 && mn < mx) begin
      hi = gentle ? mn + 4 : mn + 12;
      if (hi > mx - 1) hi = mx - 1;
      h = $urandom_range(mn, hi);
    end else if (r < 60) begin
      case ($urandom_range(0, 3))
        0: h = mn - 1;
        1: h = mn;
        2: h = mx - 1;
        default: h = mx;
      endcase
    end else if (r < 75 && lp <= 100) begin
      h = $urandom_range(lp > 0 ? lp - 1 : 0, lp + 2);
    end else begin
      h = $urandom_range(0, 8);
    end
    if (h < 0) h = 0;
    if (h > lp + 2) h = lp + 2;
    send_run(1'b1, h + 1);
    r = gentle ? 0 : $urandom_range(0, 99);
    if (r < 50) begin
      hi = (w < 12) ? w : 12;
      if (gentle && hi > 6) hi = 6;
      if (hi < 2) hi = 2;
      k = $urandom_range(2, hi);
    end else if (r < 80 && w <= 100) begin
      k = $urandom_range(w > 1 ? w - 1 : 1, w + 2);
    end else begin
      k = $urandom_range(1, 10);
    end
    send_run(1'b0, k);
  endtask

  task automatic run_phase(int budget, bit gentle);
    int start;
    start = n_sent;
    while (n_sent - start < budget) run_episode(gentle);
    burst = 1'b0;
  endtask

  // With long 4, min 1, max 3, window 4: presses before any release,
  // a two-click group, a long press, a press held too long for a click, and a
  // window that runs out while the button is down.
  task automatic run_directed();
    string seq;
    seq = "11 0110 0110 0000 11111 011110 01100111 0000";
    for (int i = 0; i < seq.len(); i++) begin
      if (seq.substr(i, i) == "1") send_sample(1'b1);
      else if (seq.substr(i, i) == "0") send_sample(1'b0);
    end
  endtask

  initial begin
    click_sb = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_regs(4, 1, 3, 4);
    run_directed();

    write_regs(20, 3, 10, 12);
    run_phase(130, 1'b0);

    // smallest thresholds: one-tick clicks, two-tick long press
    write_regs(1, 0, 1, 1);
    run_phase(200, 1'b0);

    // short range empty, no release counts as a click
    write_regs(8, 7, 3, 6);
    run_phase(150, 1'b0);

    // long chains of clicks to push the count into saturation
    write_regs(40, 0, 1023, 30);
    run_phase(250, 1'b1);

    // largest thresholds: hold count runs up to its ceiling
    write_regs(1023, 1, 1022, 1023);
    send_run(1'b0, 3);
    send_run(1'b1, 1030);
    send_run(1'b0, 3);
    run_phase(50, 1'b1);

    drain();
    repeat (10) @(negedge clk);
    if (click_sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
